// File: hw/rtl/sil_pkg.sv
package sil_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned TagW = 32;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdInsert = 2'd1,
    CmdLookup = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StRsvd     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] sym_start;
    logic [63:0] sym_size;
    logic [31:0] sym_tag;
    logic [63:0] lookup_address;
    logic [63:0] origin_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_tag;
    logic [63:0] found_offset;
    logic [63:0] echoed_origin;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic clear;     // count to zero
    logic rd;        // read entry at ptr
    logic ptr_init;  // ptr = count-1 (ins/search)
    logic ptr_dec;
    logic shift;     // write entry ptr+1 from read data
    logic ins_wr;    // write new entry at ptr+1
    logic first;     // latch first candidate start
    logic set_found;
    logic set_nf;
    logic set_full;
    logic set_ok;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic     cmd_clear;
    logic     cmd_ins;
    logic     cmd_look;
    logic     full;
    logic     empty;
    logic     ptr_zero;
    logic     key_ge;     // key >= rd start
    logic     hit;        // addr in span of rd entry
    logic     below;      // rd entry ends below first
  } sts_t;

endpackage

// File: hw/rtl/sil_datapath.sv
module sil_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sil_pkg::req_t req_i,
  input  sil_pkg::ctl_t ctl_i,
  output sil_pkg::sts_t sts_o,
  output sil_pkg::rsp_t rsp_o
);

  logic [63:0] mem_start [sil_pkg::TableDepth];
  logic [63:0] mem_size  [sil_pkg::TableDepth];
  logic [sil_pkg::TagW-1:0] mem_tag [sil_pkg::TableDepth];

  sil_pkg::req_t req_q;
  logic [sil_pkg::CntW-1:0] cnt_q;
  logic [sil_pkg::IdxW-1:0] ptr_q;
  logic [63:0] rs_q, rz_q, first_q;
  logic [sil_pkg::TagW-1:0] rt_q;
  sil_pkg::rsp_t rsp_q;

  logic [63:0] key;
  logic [sil_pkg::IdxW-1:0] wa;
  logic [64:0] rend;
  logic [63:0] diff;

  assign key  = (req_q.command == sil_pkg::CmdInsert) ? req_q.sym_start : req_q.lookup_address;
  assign wa   = ptr_q + sil_pkg::IdxW'(1);
  assign rend = {1'b0, rs_q} + {1'b0, rz_q};
  assign diff = req_q.lookup_address - rs_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rs_q <= mem_start[ptr_q];
      rz_q <= mem_size[ptr_q];
      rt_q <= mem_tag[ptr_q];
    end
    if (ctl_i.shift) begin
      mem_start[wa] <= rs_q;
      mem_size[wa]  <= rz_q;
      mem_tag[wa]   <= rt_q;
    end else if (ctl_i.ins_wr) begin
      mem_start[wa] <= req_q.sym_start;
      mem_size[wa]  <= req_q.sym_size;
      mem_tag[wa]   <= req_q.sym_tag[sil_pkg::TagW-1:0];
    end
    if (ctl_i.load) req_q <= req_i;
    if (ctl_i.first) first_q <= rs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      if (ctl_i.clear) cnt_q <= '0;
      else if (ctl_i.ins_wr) cnt_q <= cnt_q + sil_pkg::CntW'(1);
      if (ctl_i.ptr_init) ptr_q <= sil_pkg::IdxW'(cnt_q - sil_pkg::CntW'(1));
      else if (ctl_i.ptr_dec) ptr_q <= ptr_q - sil_pkg::IdxW'(1);
    end
  end

  // insert at index 0 writes wa = ptr+1 with ptr = all ones
  always_ff @(posedge clk_i) begin
    if (ctl_i.set_found) begin
      rsp_q.status        <= sil_pkg::StOk;
      rsp_q.found_tag     <= 32'(rt_q);
      rsp_q.found_offset  <= diff;
      rsp_q.echoed_origin <= req_q.origin_address;
    end else if (ctl_i.set_nf || ctl_i.set_full || ctl_i.set_ok) begin
      rsp_q.status <= ctl_i.set_nf ? sil_pkg::StNotFound :
                      ctl_i.set_full ? sil_pkg::StFull : sil_pkg::StOk;
      rsp_q.found_tag     <= '0;
      rsp_q.found_offset  <= '0;
      rsp_q.echoed_origin <= '0;
    end
  end

  assign rsp_o = rsp_q;

  assign sts_o.cmd_clear = req_q.command == sil_pkg::CmdClear;
  assign sts_o.cmd_ins   = req_q.command == sil_pkg::CmdInsert;
  assign sts_o.cmd_look  = req_q.command == sil_pkg::CmdLookup;
  assign sts_o.full      = cnt_q >= sil_pkg::CntW'(sil_pkg::TableDepth);
  assign sts_o.empty     = cnt_q == '0;
  assign sts_o.ptr_zero  = ptr_q == '0;
  assign sts_o.key_ge    = key >= rs_q;
  assign sts_o.hit       = diff < rz_q;
  assign sts_o.below     = !rend[64] && (rend[63:0] < first_q);

endmodule

// File: hw/rtl/sil_ctrl.sv
module sil_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  sil_pkg::sts_t sts_i,
  output sil_pkg::ctl_t ctl_o
);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SDec   = 7'b0000010,
    SRd    = 7'b0000100,
    SIns   = 7'b0001000,
    SFirst = 7'b0010000,
    SLook  = 7'b0100000,
    SOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   rvalid_q, rvalid_d;
  logic   firstf_q, firstf_d;
  // ins: 1 = slot 0 chosen without a further entry read (ptr wrapped)
  logic   atzero_q, atzero_d;

  assign req_ready_o = (state_q == SIdle) && !rvalid_q;
  assign rsp_valid_o = rvalid_q;

  always_comb begin
    state_d  = state_q;
    rvalid_d = rvalid_q && !rsp_ready_i;
    firstf_d = firstf_q;
    atzero_d = atzero_q;
    ctl_o    = '0;
    case (state_q)
      SIdle: begin
        if (req_valid_i && req_ready_o) begin
          ctl_o.load = 1'b1;
          state_d    = SDec;
        end
      end
      SDec: begin
        firstf_d = 1'b1;
        atzero_d = 1'b0;
        if (sts_i.cmd_clear) begin
          ctl_o.clear  = 1'b1;
          ctl_o.set_ok = 1'b1;
          state_d      = SOut;
        end else if (sts_i.cmd_ins) begin
          if (sts_i.full) begin
            ctl_o.set_full = 1'b1;
            state_d        = SOut;
          end else begin
            ctl_o.ptr_init = 1'b1;
            atzero_d       = sts_i.empty;
            state_d        = sts_i.empty ? SIns : SRd;
          end
        end else if (sts_i.cmd_look) begin
          if (sts_i.empty) begin
            ctl_o.set_nf = 1'b1;
            state_d      = SOut;
          end else begin
            ctl_o.ptr_init = 1'b1;
            state_d        = SRd;
          end
        end else begin
          ctl_o.set_ok = 1'b1;
          state_d      = SOut;
        end
      end
      SRd: begin
        ctl_o.rd = 1'b1;
        state_d  = sts_i.cmd_ins ? SIns : (firstf_q ? SFirst : SLook);
      end
      SIns: begin
        if (atzero_q || sts_i.key_ge) begin
          ctl_o.ins_wr = 1'b1;
          ctl_o.set_ok = 1'b1;
          state_d      = SOut;
        end else begin
          ctl_o.shift = 1'b1;
          if (sts_i.ptr_zero) begin
            ctl_o.ptr_dec = 1'b1;
            atzero_d      = 1'b1;
            state_d       = SIns;
          end else begin
            ctl_o.ptr_dec = 1'b1;
            state_d       = SRd;
          end
        end
      end
      SFirst: begin
        // searching for upper bound: first entry with start <= addr
        if (sts_i.key_ge) begin
          ctl_o.first = 1'b1;
          firstf_d    = 1'b0;
          state_d     = SLook;
        end else if (sts_i.ptr_zero) begin
          ctl_o.set_nf = 1'b1;
          state_d      = SOut;
        end else begin
          ctl_o.ptr_dec = 1'b1;
          state_d       = SRd;
        end
      end
      SLook: begin
        if (!sts_i.key_ge) begin
          ctl_o.set_nf = 1'b1;
          state_d      = SOut;
        end else if (sts_i.hit) begin
          ctl_o.set_found = 1'b1;
          state_d         = SOut;
        end else if (!firstf_q && sts_i.below) begin
          ctl_o.set_nf = 1'b1;
          state_d      = SOut;
        end else if (sts_i.ptr_zero) begin
          ctl_o.set_nf = 1'b1;
          state_d      = SOut;
        end else begin
          ctl_o.ptr_dec = 1'b1;
          state_d       = SRd;
        end
      end
      SOut: begin
        rvalid_d = 1'b1;
        state_d  = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      rvalid_q <= 1'b0;
      firstf_q <= 1'b0;
      atzero_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      firstf_q <= firstf_d;
      atzero_q <= atzero_d;
    end
  end

endmodule

// File: hw/rtl/symbol_interval_lookup.sv
// Sorted symbol table with address lookup.
// Request channel (req_valid_i/req_ready_o, req_i): command clear, insert
// or lookup. Response channel (rsp_valid_o/rsp_ready_i, rsp_o): exactly one
// response per request, in order.
// One request at a time. Clear, full, nop and lookup on an empty table answer
// from the decode state alone. Insert reads entries from the top down, shifting
// each entry with start above the new one up by one index, then writes the new
// entry. Lookup reads down to the first entry with start <= address, then on
// until a hit, an entry ending below that first start, or index 0. The loop is one
// registered read of the single table port per step, then a compare.
// The next request can be taken in the cycle after the response has been taken.
// Reset clears the entry count and the handshakes; table contents are
// undefined but never read past the count.
// A stalled response holds its value until rsp_ready_i.
module symbol_interval_lookup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sil_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output sil_pkg::rsp_t rsp_o
);

  sil_pkg::ctl_t ctl;
  sil_pkg::sts_t sts;

  sil_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  sil_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .ctl_i(ctl), .sts_o(sts), .rsp_o
  );

endmodule

// File: hw/rtl/sil_checker.sv
module sil_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input sil_pkg::rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped while stalled");

  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken with response pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o && !rsp_valid_o)
    else $error("no busy period after request");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.status != sil_pkg::StRsvd)
    else $error("bad status");

  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != sil_pkg::StOk |-> rsp_o.found_tag == '0)
    else $error("tag on miss");

endmodule

bind symbol_interval_lookup sil_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);

// File: verif/symbol_interval_lookup_test.sv
module symbol_interval_lookup_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = sil_pkg::TableDepth;
  localparam int unsigned RandomRequests = 850;
  localparam longint unsigned CycleLimit = 3_000_000;

  logic           clk_i;
  logic           rst_ni;
  logic           req_valid_i;
  logic           req_ready_o;
  sil_pkg::req_t  req_i;
  logic           rsp_valid_o;
  logic           rsp_ready_i;
  sil_pkg::rsp_t  rsp_o;

  symbol_interval_lookup u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // shadow symbol table
  logic [63:0]              sym_start_q [Depth];
  logic [63:0]              sym_size_q  [Depth];
  logic [sil_pkg::TagW-1:0] sym_tag_q   [Depth];
  int unsigned              sym_count;

  sil_pkg::rsp_t pending_rsp_q[$];
  int    error_count;
  bit    sender_done;
  bit    quiet_phase;
  bit    hold_rsp;
  longint unsigned cycle_count;

  typedef struct {
    sil_pkg::req_t req;
    bit            has_rsp;
    sil_pkg::rsp_t rsp;
  } vector_t;

  vector_t directed_vec[$];

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  function automatic int unsigned count_at_or_below(logic [63:0] addr);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = sym_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (addr >= sym_start_q[mid]) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic sil_pkg::rsp_t resolve_request(sil_pkg::req_t req);
    sil_pkg::rsp_t rsp;
    int unsigned   pos;
    int unsigned   k;
    logic [63:0]   first_start;
    logic [64:0]   span_end;
    rsp = '0;
    rsp.status = sil_pkg::StOk;
    case (sil_pkg::cmd_e'(req.command))
      sil_pkg::CmdClear: begin
        sym_count = 0;
      end
      sil_pkg::CmdInsert: begin
        if (sym_count >= Depth) begin
          rsp.status = sil_pkg::StFull;
        end else begin
          pos = count_at_or_below(req.sym_start);
          for (int unsigned i = sym_count; i > pos; i--) begin
            sym_start_q[i] = sym_start_q[i-1];
            sym_size_q[i]  = sym_size_q[i-1];
            sym_tag_q[i]   = sym_tag_q[i-1];
          end
          sym_start_q[pos] = req.sym_start;
          sym_size_q[pos]  = req.sym_size;
          sym_tag_q[pos]   = req.sym_tag[sil_pkg::TagW-1:0];
          sym_count++;
        end
      end
      sil_pkg::CmdLookup: begin
        rsp.status = sil_pkg::StNotFound;
        pos = count_at_or_below(req.lookup_address);
        if (pos > 0) begin
          first_start = sym_start_q[pos-1];
          for (int unsigned i = pos; i > 0; i--) begin
            k = i - 1;
            if (req.lookup_address < sym_start_q[k]) break;
            if (req.lookup_address - sym_start_q[k] < sym_size_q[k]) begin
              rsp.status        = sil_pkg::StOk;
              rsp.found_tag     = 32'(sym_tag_q[k]);
              rsp.found_offset  = req.lookup_address - sym_start_q[k];
              rsp.echoed_origin = req.origin_address;
              break;
            end
            span_end = {1'b0, sym_start_q[k]} + {1'b0, sym_size_q[k]};
            if (span_end < {1'b0, first_start}) break;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic sil_pkg::req_t make_req(sil_pkg::cmd_e cmd, logic [63:0] s,
                                             logic [63:0] z, logic [31:0] t,
                                             logic [63:0] a, logic [63:0] o);
    sil_pkg::req_t r;
    r.command        = cmd;
    r.sym_start      = s;
    r.sym_size       = z;
    r.sym_tag        = t;
    r.lookup_address = a;
    r.origin_address = o;
    return r;
  endfunction

  function automatic sil_pkg::rsp_t make_rsp(sil_pkg::status_e st, logic [31:0] t,
                                             logic [63:0] off, logic [63:0] o);
    sil_pkg::rsp_t r;
    r.status        = st;
    r.found_tag     = t;
    r.found_offset  = off;
    r.echoed_origin = o;
    return r;
  endfunction

  task automatic add_row(sil_pkg::req_t req, bit has_rsp, sil_pkg::rsp_t rsp);
    vector_t v;
    v.req     = req;
    v.has_rsp = has_rsp;
    v.rsp     = rsp;
    directed_vec.push_back(v);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one request, held until accepted; expectation queued at acceptance
  task automatic send_request(sil_pkg::req_t req, bit has_rsp, sil_pkg::rsp_t want);
    sil_pkg::rsp_t predicted;
    if (!quiet_phase) begin
      while ($urandom_range(99) < 25) begin
        req_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_valid_i <= 1'b1;
    req_i       <= req;
    do @(posedge clk_i); while (!req_ready_o);
    predicted = resolve_request(req);
    if (has_rsp && predicted != want) begin
      report_mismatch("table row", 64'(predicted.status), 64'(want.status));
    end
    pending_rsp_q.push_back(predicted);
  endtask

  function automatic sil_pkg::req_t random_request(int unsigned addr_span);
    sil_pkg::req_t r;
    int unsigned   pick;
    logic [63:0]   base;
    pick = $urandom_range(99);
    base = 64'h4000_0000;
    r = make_req(sil_pkg::CmdNop, rand64(), rand64(), $urandom(), rand64(), rand64());
    if (addr_span != 0) begin
      r.sym_start      = base + 64'($urandom_range(addr_span));
      r.sym_size       = 64'($urandom_range(64));
      r.lookup_address = base + 64'($urandom_range(addr_span + 80));
    end else if (pick[0]) begin
      r.sym_size = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(3));
    end
    if (pick < 2) r.command = sil_pkg::CmdClear;
    else if (pick < 42) r.command = sil_pkg::CmdInsert;
    else if (pick < 97) r.command = sil_pkg::CmdLookup;
    else r.command = sil_pkg::CmdNop;
    return r;
  endfunction

  initial begin
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    sym_count   = 0;
    error_count = 0;
    sender_done = 1'b0;
    quiet_phase = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h0, 64'h1234), 1,
            make_rsp(sil_pkg::StNotFound, '0, '0, '0));
    add_row(make_req(sil_pkg::CmdInsert, 64'h1000, 64'h100, 32'hffff_ffff, '0, '0), 1,
            make_rsp(sil_pkg::StOk, '0, '0, '0));
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h0fff, 64'h1), 1,
            make_rsp(sil_pkg::StNotFound, '0, '0, '0));
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h1000, 64'hffff_ffff_ffff_ffff), 1,
            make_rsp(sil_pkg::StOk, 32'hffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff));
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h10ff, 64'h5), 1,
            make_rsp(sil_pkg::StOk, 32'hffff_ffff, 64'hff, 64'h5));
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h1100, 64'h5), 1,
            make_rsp(sil_pkg::StNotFound, '0, '0, '0));
    add_row(make_req(sil_pkg::CmdInsert, 64'h1000, 64'h0, 32'h2, '0, '0), 0, '0);
    add_row(make_req(sil_pkg::CmdInsert, 64'h1080, 64'h10, 32'h3, '0, '0), 0, '0);
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h1084, 64'h6), 0, '0);
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h10a0, 64'h7), 0, '0);
    add_row(make_req(sil_pkg::CmdInsert, 64'hffff_ffff_ffff_ff00, 64'hffff_ffff_ffff_ffff,
                     32'h0, '0, '0), 0, '0);
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'hffff_ffff_ffff_ffff, 64'h8), 0, '0);
    add_row(make_req(sil_pkg::CmdInsert, 64'h0, 64'hffff_ffff_ffff_ffff, 32'h5555_aaaa,
                     '0, '0), 0, '0);
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h2000, 64'h9), 0, '0);
    add_row(make_req(sil_pkg::CmdNop, 64'h1, 64'h1, 32'h1, 64'h1, 64'h1), 1,
            make_rsp(sil_pkg::StOk, '0, '0, '0));
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h0, 64'ha), 0, '0);
    add_row(make_req(sil_pkg::CmdClear, '0, '0, '0, '0, '0), 1,
            make_rsp(sil_pkg::StOk, '0, '0, '0));
    add_row(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'h1000, 64'hb), 1,
            make_rsp(sil_pkg::StNotFound, '0, '0, '0));
    foreach (directed_vec[i]) begin
      send_request(directed_vec[i].req, directed_vec[i].has_rsp, directed_vec[i].rsp);
    end

    // fill to full with small spans, then one overflow insert
    for (int i = 0; i < Depth; i++) begin
      send_request(make_req(sil_pkg::CmdInsert, 64'(i * 16 + $urandom_range(3)), 64'd8,
                            $urandom(), '0, '0), 0, '0);
    end
    send_request(make_req(sil_pkg::CmdInsert, rand64(), rand64(), $urandom(), '0, '0), 1,
                 make_rsp(sil_pkg::StFull, '0, '0, '0));
    for (int i = 0; i < 20; i++) begin
      send_request(make_req(sil_pkg::CmdLookup, '0, '0, '0, 64'($urandom_range(4200)),
                            rand64()), 0, '0);
    end
    send_request(make_req(sil_pkg::CmdClear, '0, '0, '0, '0, '0), 0, '0);

    for (int n = 0; n < RandomRequests; n++) begin
      quiet_phase = (n >= 300 && n < 450);
      if (n % 200 == 199) begin
        send_request(make_req(sil_pkg::CmdClear, '0, '0, '0, '0, '0), 0, '0);
      end else begin
        send_request(random_request((n % 4 == 3) ? 0 : 400), 0, '0);
      end
    end
    req_valid_i <= 1'b0;
    sender_done = 1'b1;
  end

  // response side
  initial begin
    rsp_ready_i = 1'b0;
    hold_rsp    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_ready_i <= 1'b0;
      end else if (quiet_phase) begin
        rsp_ready_i <= 1'b1;
      end else begin
        rsp_ready_i <= ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    hold_rsp = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rsp = 1'b0;
  end

  always @(posedge clk_i) begin
    sil_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", 64'(rsp_o.status), '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_o.status != want.status)
          report_mismatch("status", 64'(rsp_o.status), 64'(want.status));
        if (rsp_o.found_tag != want.found_tag)
          report_mismatch("found_tag", 64'(rsp_o.found_tag), 64'(want.found_tag));
        if (rsp_o.found_offset != want.found_offset)
          report_mismatch("found_offset", rsp_o.found_offset, want.found_offset);
        if (rsp_o.echoed_origin != want.echoed_origin)
          report_mismatch("echoed_origin", rsp_o.echoed_origin, want.echoed_origin);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    wait (sender_done);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
